// ===== rtl/pdsst_pkg.sv =====
package pdsst_pkg;

  localparam int MAX_DOMAINS_DEF = 16;
  localparam int MAX_SLOTS_DEF   = 8;

  localparam int KEY_W = 32;
  localparam int SIG_W = 32;
  localparam int CFG_W = 4;

  localparam logic [CFG_W-1:0] SLOTS_RESET = 4'd8;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_GET = 1'b1;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic finish;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/per_domain_signal_slot_table_core.sv =====
// A table of domain rows, each holding a limited number of 32-bit signal slots where
// zero means empty. An add stores its signal in the first empty slot of the row whose
// key matches, or opens a new row when the key is unknown; a get returns and clears the
// first non-zero slot, scanning rows in the order they were opened. The slot limit from
// the configuration port is captured when a row is opened. Rows are read one per cycle
// through the single read port of the row memory; a scan stops at the first row whose
// key matches for an add, or that holds a signal for a get, or after the last open row.
// The next item is accepted once the result has moved to the output register, even
// while that result still waits to be taken.
module per_domain_signal_slot_table_core
  import pdsst_pkg::*;
#(
  parameter int MAX_DOMAINS = MAX_DOMAINS_DEF,
  parameter int MAX_SLOTS   = MAX_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [KEY_W+SIG_W-1:0] s_axis_tdata,   // domain, signal
  input  logic [0:0]             s_axis_tuser,   // command
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [KEY_W+SIG_W-1:0] m_axis_tdata,   // domain_out, value_out
  output logic [0:0]             m_axis_tuser,   // ok
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  pdsst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pdsst_datapath #(
    .MAX_DOMAINS (MAX_DOMAINS),
    .MAX_SLOTS   (MAX_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .in_kind   (s_axis_tuser[0]),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_ok    (m_axis_tuser[0])
  );

endmodule

// ===== rtl/pdsst_ctrl.sv =====
module pdsst_ctrl
  import pdsst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.finish) begin
          cmd.commit = 1'b1;
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/pdsst_datapath.sv =====
module pdsst_datapath
  import pdsst_pkg::*;
#(
  parameter int MAX_DOMAINS = MAX_DOMAINS_DEF,
  parameter int MAX_SLOTS   = MAX_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ctl_cmd_t                 cmd,
  output dp_status_t               status,
  input  logic [KEY_W+SIG_W-1:0]   in_data,
  input  logic                     in_kind,
  input  logic                     cfg_valid,
  input  logic [CFG_W-1:0]         cfg_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [KEY_W+SIG_W-1:0]   out_data,
  output logic                     out_ok
);

  localparam int IW    = (MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1;
  localparam int CW    = $clog2(MAX_DOMAINS + 1);
  localparam int SW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int LW    = $clog2(MAX_SLOTS + 1);
  localparam int ROW_W = MAX_SLOTS * SIG_W;

  logic [ROW_W-1:0] slot_mem [MAX_DOMAINS];
  logic [KEY_W-1:0] key_mem  [MAX_DOMAINS];
  logic [LW-1:0]    lim_mem  [MAX_DOMAINS];

  logic [CFG_W-1:0] cfg_slots;
  logic [CW-1:0]    count;
  logic             cmd_q;
  logic [KEY_W-1:0] dom_q;
  logic [SIG_W-1:0] sig_q;
  logic [CW-1:0]    rd_cnt;
  logic [CW-1:0]    chk_cnt;
  logic             chk_valid;
  logic [ROW_W-1:0] row_q;
  logic [KEY_W-1:0] key_q;
  logic [LW-1:0]    lim_q;
  logic             res_ok;
  logic [KEY_W-1:0] res_dom;
  logic [SIG_W-1:0] res_val;

  logic [LW-1:0]    eff_limit;
  logic             chk_live;
  logic             end_scan;
  logic             slot_found;
  logic [SW-1:0]    slot_idx;
  logic [SIG_W-1:0] slot_sel;
  logic             row_match;
  logic             row_hit;
  logic             can_open;
  logic             open_row;
  logic [ROW_W-1:0] upd_row;
  logic             mem_we;
  logic [IW-1:0]    wr_addr;
  logic [ROW_W-1:0] wr_row;

  always_comb begin
    if (cfg_slots == '0) begin
      eff_limit = LW'(1);
    end else if (int'(cfg_slots) > MAX_SLOTS) begin
      eff_limit = LW'(MAX_SLOTS);
    end else begin
      eff_limit = LW'(cfg_slots);
    end
  end

  assign chk_live  = chk_valid && (chk_cnt < count);
  assign end_scan  = chk_valid && !(chk_cnt < count);
  assign can_open  = count < CW'(MAX_DOMAINS);

  always_comb begin
    slot_found = 1'b0;
    slot_idx   = '0;
    slot_sel   = '0;
    for (int s = 0; s < MAX_SLOTS; s++) begin
      if (!slot_found && (s < int'(lim_q)) &&
          ((cmd_q == CMD_GET) ? (row_q[s*SIG_W +: SIG_W] != '0)
                              : (row_q[s*SIG_W +: SIG_W] == '0))) begin
        slot_found = 1'b1;
        slot_idx   = SW'(s);
        slot_sel   = row_q[s*SIG_W +: SIG_W];
      end
    end
  end

  always_comb begin
    upd_row = row_q;
    for (int s = 0; s < MAX_SLOTS; s++) begin
      if (SW'(s) == slot_idx) begin
        upd_row[s*SIG_W +: SIG_W] = (cmd_q == CMD_GET) ? '0 : sig_q;
      end
    end
  end

  assign row_match = chk_live && (cmd_q == CMD_ADD) && (key_q == dom_q);
  assign row_hit   = chk_live && (cmd_q == CMD_GET) && slot_found;
  assign open_row  = end_scan && (cmd_q == CMD_ADD) && can_open;

  assign status.finish   = row_match || row_hit || end_scan;
  assign status.out_free = !out_valid || out_ready;

  assign mem_we  = cmd.commit && (open_row || ((row_match || row_hit) && slot_found));
  assign wr_addr = open_row ? count[IW-1:0] : chk_cnt[IW-1:0];
  assign wr_row  = open_row ? ROW_W'(sig_q) : upd_row;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[wr_addr] <= wr_row;
    end
    if (cmd.commit && open_row) begin
      key_mem[wr_addr] <= dom_q;
      lim_mem[wr_addr] <= eff_limit;
    end
    row_q <= slot_mem[rd_cnt[IW-1:0]];
    key_q <= key_mem[rd_cnt[IW-1:0]];
    lim_q <= lim_mem[rd_cnt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_slots <= SLOTS_RESET;
      count     <= '0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cfg_slots <= cfg_data;
      end
      if (cmd.commit && open_row) begin
        count <= count + CW'(1);
      end
      if (cmd.load) begin
        chk_valid <= 1'b0;
      end else if (cmd.scan) begin
        chk_valid <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q  <= in_kind;
      dom_q  <= in_data[KEY_W-1:0];
      sig_q  <= in_data[KEY_W +: SIG_W];
      rd_cnt <= '0;
    end else if (cmd.scan) begin
      rd_cnt  <= rd_cnt + CW'(1);
      chk_cnt <= rd_cnt;
    end
    if (cmd.commit) begin
      res_ok  <= open_row || ((row_match || row_hit) && slot_found);
      res_dom <= row_hit ? key_q : '0;
      res_val <= row_hit ? slot_sel : '0;
    end
    if (cmd.emit) begin
      out_ok   <= res_ok;
      out_data <= {res_val, res_dom};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= MAX_DOMAINS)
    else $error("domain count beyond table size");

  a_count_steady: assert property (@(posedge clk) disable iff (rst)
    !(cmd.commit && open_row) |=> $stable(count))
    else $error("domain count moved without opening a row");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result emitted over a pending one");

  a_get_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && row_hit) |=> (res_ok && res_val != '0))
    else $error("get returned an empty slot");

endmodule

// ===== bench/per_domain_signal_slot_table_core_tb.sv =====
`timescale 1ns / 100ps

module per_domain_signal_slot_table_core_tb;
  import pdsst_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int POOL_SIZE   = 20;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 225;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic             ok;
    logic [KEY_W-1:0] dom;
    logic [SIG_W-1:0] val;
  } table_result_t;

  class slot_table_scoreboard;
    logic [KEY_W-1:0] row_key [MAX_DOMAINS_DEF];
    bit               row_open [MAX_DOMAINS_DEF];
    int               row_limit [MAX_DOMAINS_DEF];
    logic [SIG_W-1:0] slot_sig [MAX_DOMAINS_DEF][MAX_SLOTS_DEF];
    int               rows_opened;
    logic [CFG_W-1:0] slots_cfg;
    table_result_t    expected_q [$];
    int               errors;

    function new();
      rows_opened = 0;
      slots_cfg   = SLOTS_RESET;
      errors      = 0;
      foreach (row_open[r]) begin
        row_open[r]  = 1'b0;
        row_limit[r] = 0;
        row_key[r]   = '0;
      end
      foreach (slot_sig[r, s]) slot_sig[r][s] = '0;
    endfunction

    function void set_slots(logic [CFG_W-1:0] value);
      slots_cfg = value;
    endfunction

    function bit store_signal(logic [KEY_W-1:0] dom, logic [SIG_W-1:0] sig);
      int r;
      for (r = 0; r < MAX_DOMAINS_DEF; r++) begin
        if (row_open[r] && row_key[r] == dom) begin
          for (int s = 0; s < row_limit[r]; s++) begin
            if (slot_sig[r][s] == '0) begin
              slot_sig[r][s] = sig;
              return 1'b1;
            end
          end
          return 1'b0;
        end
      end
      if (rows_opened >= MAX_DOMAINS_DEF) return 1'b0;
      r = rows_opened;
      rows_opened++;
      row_open[r] = 1'b1;
      row_key[r]  = dom;
      if (slots_cfg == 0) begin
        row_limit[r] = 1;
      end else if (slots_cfg > MAX_SLOTS_DEF) begin
        row_limit[r] = MAX_SLOTS_DEF;
      end else begin
        row_limit[r] = int'(slots_cfg);
      end
      for (int s = 0; s < MAX_SLOTS_DEF; s++) slot_sig[r][s] = '0;
      slot_sig[r][0] = sig;
      return 1'b1;
    endfunction

    function table_result_t take_signal();
      table_result_t res;
      res = '0;
      for (int r = 0; r < MAX_DOMAINS_DEF; r++) begin
        if (row_open[r]) begin
          for (int s = 0; s < row_limit[r]; s++) begin
            if (slot_sig[r][s] != '0) begin
              res.ok = 1'b1;
              res.dom = row_key[r];
              res.val = slot_sig[r][s];
              slot_sig[r][s] = '0;
              return res;
            end
          end
        end
      end
      return res;
    endfunction

    function void note_item(logic cmd, logic [KEY_W-1:0] dom, logic [SIG_W-1:0] sig);
      table_result_t res;
      if (cmd == CMD_ADD) begin
        res = '0;
        res.ok = store_signal(dom, sig);
      end else begin
        res = take_signal();
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(logic ok, logic [KEY_W-1:0] dom, logic [SIG_W-1:0] val);
      table_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction: ok=%0d domain=%h value=%h",
                 $time, ok, dom, val);
        return;
      end
      want = expected_q.pop_front();
      if (ok !== want.ok) begin
        errors++;
        $display("%0t: ok expected %0d actual %0d", $time, want.ok, ok);
      end
      if (dom !== want.dom) begin
        errors++;
        $display("%0t: domain_out expected %h actual %h", $time, want.dom, dom);
      end
      if (val !== want.val) begin
        errors++;
        $display("%0t: value_out expected %h actual %h", $time, want.val, val);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [KEY_W+SIG_W-1:0] s_axis_tdata;
  logic [0:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [KEY_W+SIG_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data;

  slot_table_scoreboard sb;
  logic [KEY_W-1:0]     key_pool [POOL_SIZE];
  logic [CFG_W-1:0]     phase_slots [PHASES];
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  bit                   hold_request = 1'b0;
  int                   hold_left = 0;
  int                   cycles = 0;

  per_domain_signal_slot_table_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser[0], m_axis_tdata[KEY_W-1:0],
                      m_axis_tdata[KEY_W+SIG_W-1:KEY_W]);
    end
  end

  task automatic send_item(input logic cmd, input logic [KEY_W-1:0] dom,
                           input logic [SIG_W-1:0] sig);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sig, dom};
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_item(cmd, dom, sig);
  endtask

  task automatic send_random_item(input int pool_used);
    logic             cmd;
    logic [KEY_W-1:0] dom;
    logic [SIG_W-1:0] sig;
    cmd = ($urandom_range(99) < 50) ? CMD_GET : CMD_ADD;
    if ($urandom_range(99) < 3) begin
      dom = $urandom();
    end else begin
      dom = key_pool[$urandom_range(pool_used - 1)];
    end
    case ($urandom_range(9))
      0: begin
        sig = '0;
      end
      1: begin
        sig = '1;
      end
      default: begin
        sig = $urandom();
      end
    endcase
    send_item(cmd, dom, sig);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_slots(input logic [CFG_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_slots(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int pool_used;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    sb = new();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    phase_slots = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd9, 4'd2, 4'd6};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(CMD_GET, '0, '0);
    send_item(CMD_ADD, key_pool[0], 32'hFFFF_FFFF);
    send_item(CMD_ADD, key_pool[1], 32'h0000_0001);
    send_item(CMD_ADD, key_pool[0], '0);
    send_item(CMD_ADD, key_pool[2], '0);
    for (int i = 1; i < MAX_SLOTS_DEF; i++) send_item(CMD_ADD, key_pool[0], 32'h1 << (i * 4));
    send_item(CMD_ADD, key_pool[0], 32'hA5A5_5A5A);
    send_item(CMD_ADD, key_pool[0], '0);
    repeat (3) send_item(CMD_GET, $urandom(), $urandom());
    send_item(CMD_ADD, key_pool[0], 32'h1234_5678);
    repeat (3) send_item(CMD_GET, '1, '1);

    for (int p = 0; p < PHASES; p++) begin
      write_slots(phase_slots[p]);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_idle_pct = 28;
          recv_stall_pct = 28;
        end
      endcase
      if (p == 0) hold_request = 1'b1;
      pool_used = (5 + 2 * p < POOL_SIZE) ? 5 + 2 * p : POOL_SIZE;
      repeat (PHASE_ITEMS) send_random_item(pool_used);
    end

    drain_results();
    repeat (MAX_DOMAINS_DEF + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pdsst_pkg.sv
rtl/pdsst_ctrl.sv
rtl/pdsst_datapath.sv
rtl/per_domain_signal_slot_table_core.sv
bench/per_domain_signal_slot_table_core_tb.sv
